FILE: rtl/core/frf_pkg.sv
// Shared types and constants of the fragment reassembly framer.
// Used by frf_parser, frf_msg and fragment_reassembly_framer; no dependencies.
package frf_pkg;

   localparam int SEGMENT_BYTES   = 36;
   localparam int MAX_SEGMENTS    = 32;
   localparam int GLOBAL_BYTES    = 41;
   localparam int MAX_FRAME_BYTES = 250;

   localparam int HEADER_BYTES = 3;
   localparam int STORE_BYTES  = GLOBAL_BYTES + MAX_SEGMENTS * SEGMENT_BYTES;

   localparam int ADDR_W      = 11;
   localparam int ADDR_CALC_W = 13;
   localparam int SEG_POS_W   = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;

   localparam logic [7:0] MAGIC_BYTE = 8'h57;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic CSR_SYNC_ENABLED = 1'b0;
   localparam logic CSR_HOLDOFF_MS   = 1'b1;

   localparam logic [2:0] STATUS_NONE       = 3'd0;
   localparam logic [2:0] STATUS_IGNORED    = 3'd1;
   localparam logic [2:0] STATUS_ACCEPTED   = 3'd2;
   localparam logic [2:0] STATUS_ABORTED    = 3'd3;
   localparam logic [2:0] STATUS_DELIVERED  = 3'd4;
   localparam logic [2:0] STATUS_SUPPRESSED = 3'd5;

   typedef struct packed {
      logic       in_progress;
      logic [7:0] fragments_seen;
      logic [5:0] segments_stored;
   } msg_state_type;

   typedef struct packed {
      logic       close;
      logic       ignore;
      logic [7:0] index;
      logic [7:0] count;
      logic [7:0] seg_cnt;
      logic       seg_whole;
   } frame_close_type;

endpackage

FILE: rtl/core/frf_parser.sv
// Frame parser: header capture, frame filter, segment counting and store writes.
// Depends on frf_pkg; reads the message state kept by frf_msg.
module frf_parser
   import frf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             data_byte,
   input  logic                   frame_last,
   input  logic                   broadcast,
   input  logic                   sender_linked,
   input  logic                   link_connected,
   input  logic                   sync_enabled,
   input  msg_state_type          msg_state,
   output logic                   write_enable,
   output logic [ADDR_W-1:0]      write_addr,
   output logic [7:0]             write_byte,
   output frame_close_type        close_info
);

   logic [7:0]           byte_count_ff, byte_count_in, byte_count_n;
   logic [7:0]           index_ff, index_in, index_n;
   logic [7:0]           count_ff, count_in, count_n;
   logic                 rejected_ff, rejected_in, rejected_n;
   logic [SEG_POS_W-1:0] seg_pos_ff, seg_pos_in, seg_pos_n;
   logic [7:0]           seg_cnt_ff, seg_cnt_in, seg_cnt_n;

   logic                   counted;
   logic                   payload;
   logic [7:0]             off;
   logic [ADDR_CALC_W-1:0] addr_calc;
   logic                   we;

   always_comb begin
      counted      = take && (byte_count_ff < 8'(MAX_FRAME_BYTES));
      payload      = counted && (byte_count_ff >= 8'(HEADER_BYTES));
      off          = byte_count_ff - 8'(HEADER_BYTES);
      byte_count_n = byte_count_ff;
      index_n      = index_ff;
      count_n      = count_ff;
      rejected_n   = rejected_ff;
      seg_pos_n    = seg_pos_ff;
      seg_cnt_n    = seg_cnt_ff;
      addr_calc    = '0;
      we           = 1'b0;

      if (counted) begin
         byte_count_n = byte_count_ff + 8'd1;
         if (byte_count_ff == 8'd0) begin
            rejected_n = !(data_byte == MAGIC_BYTE && broadcast && sender_linked &&
                           sync_enabled && !link_connected);
         end else if (byte_count_ff == 8'd1) begin
            index_n = data_byte;
         end else if (byte_count_ff == 8'd2) begin
            count_n = data_byte;
         end
      end

      // advance segment position on payload past the global part
      if (payload && (index_ff != 8'd0 || off >= 8'(GLOBAL_BYTES))) begin
         if (seg_pos_ff == SEG_POS_W'(SEGMENT_BYTES - 1)) begin
            seg_pos_n = '0;
            seg_cnt_n = seg_cnt_ff + 8'd1;
         end else begin
            seg_pos_n = seg_pos_ff + SEG_POS_W'(1);
         end
      end

      if (payload && !rejected_ff) begin
         if (index_ff == 8'd0) begin
            addr_calc = ADDR_CALC_W'(off);
            we        = 1'b1;
         end else if (msg_state.in_progress && index_ff == msg_state.fragments_seen &&
                      msg_state.segments_stored < 6'(MAX_SEGMENTS)) begin
            addr_calc = ADDR_CALC_W'(GLOBAL_BYTES)
                      + ADDR_CALC_W'(msg_state.segments_stored) * ADDR_CALC_W'(SEGMENT_BYTES)
                      + ADDR_CALC_W'(off);
            we        = 1'b1;
         end
      end
      we = we && (addr_calc < ADDR_CALC_W'(STORE_BYTES));

      write_enable = we;
      write_addr   = we ? addr_calc[ADDR_W-1:0] : '0;
      write_byte   = we ? data_byte : 8'd0;

      close_info.close     = take && frame_last;
      close_info.ignore    = rejected_n || (byte_count_n < 8'(HEADER_BYTES));
      close_info.index     = index_n;
      close_info.count     = count_n;
      close_info.seg_cnt   = seg_cnt_n;
      close_info.seg_whole = (seg_pos_n == '0);

      // drop frame state once the last byte is taken
      if (take && frame_last) begin
         byte_count_in = '0;
         index_in      = '0;
         count_in      = '0;
         rejected_in   = 1'b0;
         seg_pos_in    = '0;
         seg_cnt_in    = '0;
      end else begin
         byte_count_in = byte_count_n;
         index_in      = index_n;
         count_in      = count_n;
         rejected_in   = rejected_n;
         seg_pos_in    = seg_pos_n;
         seg_cnt_in    = seg_cnt_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         index_ff      <= '0;
         count_ff      <= '0;
         rejected_ff   <= 1'b0;
         seg_pos_ff    <= '0;
         seg_cnt_ff    <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         index_ff      <= index_in;
         count_ff      <= count_in;
         rejected_ff   <= rejected_in;
         seg_pos_ff    <= seg_pos_in;
         seg_cnt_ff    <= seg_cnt_in;
      end
   end

endmodule

FILE: rtl/core/frf_msg.sv
// Message tracker: fragment sequencing, segment totals, holdoff timer and frame verdict.
// Depends on frf_pkg; driven by the close information from frf_parser.
module frf_msg
   import frf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            tick,
   input  frame_close_type close_info,
   input  logic [15:0]     holdoff_ms,
   output msg_state_type   msg_state,
   output logic [2:0]      frame_status,
   output logic            message_ready
);

   msg_state_type msg_ff, msg_in;
   logic [15:0]   ms_ff, ms_in;

   logic       ok;
   logic [7:0] fs_base;
   logic [7:0] fs_next;
   logic [8:0] seg_sum;

   always_comb begin
      msg_in        = msg_ff;
      ms_in         = ms_ff;
      frame_status  = STATUS_NONE;
      message_ready = 1'b0;
      ok            = 1'b1;
      fs_base       = msg_ff.fragments_seen;
      fs_next       = '0;
      seg_sum       = 9'(msg_ff.segments_stored) + 9'(close_info.seg_cnt);

      if (tick && ms_ff != 16'hFFFF) begin
         ms_in = ms_ff + 16'd1;
      end

      if (close_info.close) begin
         if (close_info.ignore) begin
            frame_status = STATUS_IGNORED;
         end else begin
            if (close_info.index == 8'd0) begin
               msg_in.in_progress     = 1'b1;
               fs_base                = '0;
               msg_in.segments_stored = (close_info.seg_cnt > 8'(MAX_SEGMENTS)) ?
                                        6'(MAX_SEGMENTS) : close_info.seg_cnt[5:0];
            end else if (msg_ff.in_progress && close_info.index == msg_ff.fragments_seen &&
                         close_info.seg_whole) begin
               if (msg_ff.segments_stored < 6'(MAX_SEGMENTS)) begin
                  msg_in.segments_stored = (seg_sum > 9'(MAX_SEGMENTS)) ?
                                           6'(MAX_SEGMENTS) : seg_sum[5:0];
               end
            end else begin
               ok = 1'b0;
            end

            fs_next = fs_base + 8'd1;
            if (!ok) begin
               msg_in       = '0;
               frame_status = STATUS_ABORTED;
            end else if (fs_next < close_info.count) begin
               msg_in.fragments_seen = fs_next;
               frame_status          = STATUS_ACCEPTED;
            end else begin
               msg_in = '0;
               if (ms_ff > holdoff_ms) begin
                  message_ready = 1'b1;
                  ms_in         = '0;
                  frame_status  = STATUS_DELIVERED;
               end else begin
                  frame_status  = STATUS_SUPPRESSED;
               end
            end
         end
      end

      msg_state = msg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_ff <= '0;
         ms_ff  <= '0;
      end else begin
         msg_ff <= msg_in;
         ms_ff  <= ms_in;
      end
   end

endmodule

FILE: rtl/core/fragment_reassembly_framer.sv
// Top level of the fragment reassembly framer: control registers, handshake, result register.
// Depends on frf_pkg, frf_parser and frf_msg.
//
//   port group  direction  handshake            contents
//   req_*       in         req_valid/req_stall  one frame byte or one millisecond tick
//   rsp_*       out        rsp_valid/rsp_stall  store write, frame verdict, ready pulse
//   csr_*       in         csr_wr_en            sync_enabled (0), holdoff_ms (1)
//
// Each word is processed in the cycle it is accepted and its result is shown in the
// next cycle from the result register; one word per cycle is sustained while rsp_stall is low.
// A result waiting under rsp_stall holds the result register and stalls req.
// Synchronous reset sets sync_enabled to 1, holdoff_ms to 250, and clears all
// message, frame and timer state; no clearing pass follows.
module fragment_reassembly_framer
   import frf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [7:0]        req_data_byte,
   input  logic              req_frame_last,
   input  logic              req_broadcast,
   input  logic              req_sender_linked,
   input  logic              req_link_connected,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_write_enable,
   output logic [ADDR_W-1:0] rsp_write_addr,
   output logic [7:0]        rsp_write_byte,
   output logic              rsp_frame_end,
   output logic [2:0]        rsp_frame_status,
   output logic              rsp_message_ready,

   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   logic        sync_enabled_ff, sync_enabled_in;
   logic [15:0] holdoff_ms_ff, holdoff_ms_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic              we_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        wbyte_ff;
   logic              fend_ff;
   logic [2:0]        status_ff;
   logic              ready_ff;

   logic            accept;
   logic            byte_take;
   logic            tick_take;
   msg_state_type   msg_state;
   frame_close_type close_info;
   logic              we;
   logic [ADDR_W-1:0] addr;
   logic [7:0]        wbyte;
   logic [2:0]        status;
   logic              ready;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign byte_take = accept && (req_operation == OP_BYTE);
   assign tick_take = accept && (req_operation == OP_TICK);

   frf_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .take           (byte_take),
      .data_byte      (req_data_byte),
      .frame_last     (req_frame_last),
      .broadcast      (req_broadcast),
      .sender_linked  (req_sender_linked),
      .link_connected (req_link_connected),
      .sync_enabled   (sync_enabled_ff),
      .msg_state      (msg_state),
      .write_enable   (we),
      .write_addr     (addr),
      .write_byte     (wbyte),
      .close_info     (close_info)
   );

   frf_msg u_msg (
      .clock         (clock),
      .reset         (reset),
      .tick          (tick_take),
      .close_info    (close_info),
      .holdoff_ms    (holdoff_ms_ff),
      .msg_state     (msg_state),
      .frame_status  (status),
      .message_ready (ready)
   );

   always_comb begin
      sync_enabled_in = sync_enabled_ff;
      holdoff_ms_in   = holdoff_ms_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_ENABLED: sync_enabled_in = csr_wdata[0];
            CSR_HOLDOFF_MS:   holdoff_ms_in   = csr_wdata;
            default:          sync_enabled_in = sync_enabled_ff;
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_enabled_ff <= 1'b1;
         holdoff_ms_ff   <= 16'd250;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sync_enabled_ff <= sync_enabled_in;
         holdoff_ms_ff   <= holdoff_ms_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // load the result register on accept, hold it otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         we_ff     <= we;
         addr_ff   <= addr;
         wbyte_ff  <= wbyte;
         fend_ff   <= close_info.close;
         status_ff <= status;
         ready_ff  <= ready;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_write_addr    = addr_ff;
   assign rsp_write_byte    = wbyte_ff;
   assign rsp_frame_end     = fend_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_message_ready = ready_ff;

endmodule
